>>> rtl/mpq_pkg.sv
`timescale 1ns / 1ps
// mpq_pkg: types and status codes shared by the priority queue cells and top level
// no dependencies

package mpq_pkg;

  localparam int DATA_W  = 32;
  localparam int CFG_W   = 7;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // command broadcast to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                     vld;
    logic                     gt;
    logic signed [DATA_W-1:0] val;
  } cell_link_t;

endpackage

>>> rtl/mpq_cell.sv
`timescale 1ns / 1ps
// mpq_cell: one slot of the sorted cell chain, largest value at the head
// depends on mpq_pkg

module mpq_cell
  import mpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_cmd_t  cmd,
  input  cell_link_t left_link,
  input  cell_link_t right_link,
  output cell_link_t own_link
);

  logic                     vld_r;
  logic                     vld_nxt;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;
  logic                     gt;

  // new value belongs at or before this slot
  assign gt = !vld_r || (cmd.value > val_r);

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    if (cmd.ins) begin
      if (left_link.gt) begin
        vld_nxt = left_link.vld;
        val_nxt = left_link.val;
      end else if (gt) begin
        vld_nxt = 1'b1;
        val_nxt = cmd.value;
      end
    end else if (cmd.rem) begin
      vld_nxt = right_link.vld;
      val_nxt = right_link.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    val_r <= val_nxt;
  end

  assign own_link.vld = vld_r;
  assign own_link.gt  = gt;
  assign own_link.val = val_r;

endmodule

>>> rtl/max_priority_queue.sv
`timescale 1ns / 1ps
// max_priority_queue: bounded max priority queue of signed values on a chain of cells
// depends on mpq_pkg and mpq_cell
//
// channel | ports       | tdata (low bit up)              | tuser
// --------+-------------+---------------------------------+------------------
// input   | in_t*       | value[31:0]                     | op[0]
// result  | out_t*      | removed_value[31:0], count[6:0] | status[1:0]
// config  | cfg_wen     | cfg_wdata = capacity_limit[6:0] | -
//
// one request per cycle: the chain sorts in place, each cell trading with its neighbor
// one result per request, held in an output register until taken
// a stalled result blocks only the next request; rst_n clears all valid bits at once

module max_priority_queue
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [DATA_W-1:0]   in_tdata,   // value
  input  logic [0:0]          in_tuser,   // op
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // removed_value, entry_count, zero pad
  output logic [STAT_W-1:0]   out_tuser,  // status
  input  logic                cfg_wen,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  logic [CFG_W-1:0]         limit_r;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     out_vld_r;
  logic                     out_vld_nxt;
  logic signed [DATA_W-1:0] res_val_r;
  logic signed [DATA_W-1:0] res_val_nxt;
  logic [STAT_W-1:0]        res_stat_r;
  logic [STAT_W-1:0]        res_stat_nxt;
  logic [COUNT_W-1:0]       res_cnt_r;
  logic [COUNT_W-1:0]       res_cnt_nxt;
  logic                     accept;
  logic                     can_ins;
  logic                     can_rem;
  logic [LW-1:0]            count_l;
  logic [LW-1:0]            cnt_nxt_l;
  cell_cmd_t                cmd;
  cell_link_t               links [CAPACITY];
  cell_link_t               head_bound;
  cell_link_t               tail_bound;

  assign in_tready = !out_vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign count_l = LW'(count_r);
  assign can_ins = (count_l < LW'(limit_r)) && (count_l < CAP_L);
  assign can_rem = links[0].vld;

  assign cmd.ins   = accept && (in_tuser[0] == OP_INSERT) && can_ins;
  assign cmd.rem   = accept && (in_tuser[0] == OP_REMOVE) && can_rem;
  assign cmd.value = $signed(in_tdata);

  assign head_bound.vld = 1'b1;
  assign head_bound.gt  = 1'b0;
  assign head_bound.val = '0;
  assign tail_bound.vld = 1'b0;
  assign tail_bound.gt  = 1'b1;
  assign tail_bound.val = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_l;
    cell_link_t right_l;
    if (i == 0) begin : g_head
      assign left_l = head_bound;
    end else begin : g_mid
      assign left_l = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_l = tail_bound;
    end else begin : g_body
      assign right_l = links[i+1];
    end
    mpq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_link  (left_l),
      .right_link (right_l),
      .own_link   (links[i])
    );
  end

  always_comb begin
    count_nxt    = count_r;
    res_val_nxt  = res_val_r;
    res_stat_nxt = res_stat_r;
    if (cmd.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CW'(1);
    end
    if (accept) begin
      res_val_nxt  = cmd.rem ? links[0].val : '0;
      res_stat_nxt = STAT_OK;
      if (in_tuser[0] == OP_INSERT && !can_ins) begin
        res_stat_nxt = STAT_FULL;
      end else if (in_tuser[0] == OP_REMOVE && !can_rem) begin
        res_stat_nxt = STAT_EMPTY;
      end
    end
  end

  assign cnt_nxt_l   = LW'(count_nxt);
  assign res_cnt_nxt = accept ? cnt_nxt_l[COUNT_W-1:0] : res_cnt_r;
  assign out_vld_nxt = accept ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= CFG_W'(64);
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        limit_r <= cfg_wdata;
      end
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    res_cnt_r  <= res_cnt_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_cnt_r, res_val_r};
  assign out_tuser  = res_stat_r;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for max_priority_queue, predicting each result from a
// simple unordered copy of the stored values under random stalls on both streams
// depends on mpq_pkg and max_priority_queue

module tb;
  import mpq_pkg::*;

  localparam int QUEUE_DEPTH = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
  } pq_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata;
  logic [0:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [39:0]         out_tdata;
  logic [STAT_W-1:0]   out_tuser;
  logic                cfg_wen;
  logic [CFG_W-1:0]    cfg_wdata;

  pq_result_t               pending_results[$];
  logic signed [DATA_W-1:0] held_values[$];
  int                       capacity_setting;
  logic                     idle_on;
  int                       stall_left;
  int                       errors;
  int                       requests_sent;
  int                       settings_used;
  int                       removed_ok;
  int                       full_drops;
  int                       empty_removes;

  max_priority_queue #(.CAPACITY(QUEUE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void predict_request(input logic op, input logic signed [DATA_W-1:0] value);
    pq_result_t r;
    int         limit;
    int         top;
    limit = (capacity_setting > QUEUE_DEPTH) ? QUEUE_DEPTH : capacity_setting;
    r.removed = '0;
    r.status  = STAT_OK;
    if (op == OP_INSERT) begin
      if (held_values.size() < limit) held_values.push_back(value);
      else r.status = STAT_FULL;
    end else if (held_values.size() > 0) begin
      top = 0;
      for (int i = 1; i < held_values.size(); i++)
        if (held_values[i] > held_values[top]) top = i;
      r.removed = held_values[top];
      held_values.delete(top);
    end else begin
      r.status = STAT_EMPTY;
    end
    r.count = COUNT_W'(held_values.size());
    pending_results.push_back(r);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1, 2:    return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  // one input transfer; valid stays high on return
  task automatic send_request(input logic op, input logic signed [DATA_W-1:0] value);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(op, value);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] setting);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= setting;
    @(negedge clk);
    cfg_wen <= 1'b0;
    capacity_setting = setting;
    settings_used++;
  endtask

  task automatic test_value_extremes();
    send_request(OP_REMOVE, 32'sh7fff_ffff);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_INSERT, 32'sh0000_0000);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_INSERT, 32'sh8000_0001);
    for (int i = 0; i < 7; i++) send_request(OP_REMOVE, 32'sh5555_aaaa);
  endtask

  task automatic test_capacity_corners();
    // zero limit drops every insert
    write_capacity(7'd0);
    send_request(OP_INSERT, 32'sd42);
    send_request(OP_REMOVE, 32'sd0);
    write_capacity(7'd1);
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, 32'sd9);
    send_request(OP_REMOVE, 32'sd0);
    // limit lowered under the stored count keeps the entries
    write_capacity(7'd64);
    for (int i = 0; i < 4; i++) send_request(OP_INSERT, i * 1000 - 1500);
    write_capacity(7'd2);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_REMOVE, 32'sd0);
    send_request(OP_REMOVE, 32'sd0);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_REMOVE, 32'sd0);
    send_request(OP_INSERT, -32'sd5);
    send_request(OP_INSERT, 32'sd6);
  endtask

  // randomly chosen fill, drain and balanced runs push the count between empty and the limit
  task automatic run_random(input int count);
    int run_left;
    int insert_pct;
    run_left = 0;
    insert_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(10, 100);
        case ($urandom_range(0, 2))
          0:       insert_pct = 90;
          1:       insert_pct = 12;
          default: insert_pct = 55;
        endcase
      end
      run_left--;
      if ($urandom_range(1, 100) <= insert_pct) send_request(OP_INSERT, random_value());
      else send_request(OP_REMOVE, random_value());
    end
  endtask

  task automatic test_random_settings();
    logic [CFG_W-1:0] settings[10];
    settings = '{7'd127, 7'd64, 7'd1, 7'd7, 7'd0, 7'd33, 7'd100, 7'd2, 7'd85, 7'd64};
    foreach (settings[i]) begin
      write_capacity(settings[i]);
      run_random(165);
    end
  endtask

  task automatic test_full_rate_tail();
    wait_drained();
    idle_on = 1'b0;
    run_random(200);
  endtask

  always @(negedge clk) begin
    if (!rst_n || !idle_on) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: data %h status %0d",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.removed) begin
          $display("%0t: removed value expected %0d actual %0d",
                   $time, want.removed, $signed(out_tdata[31:0]));
          errors++;
        end
        if (out_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
          errors++;
        end
        if (out_tdata[38:32] !== want.count) begin
          $display("%0t: entry count expected %0d actual %0d",
                   $time, want.count, out_tdata[38:32]);
          errors++;
        end
        case (want.status)
          STAT_FULL:  full_drops++;
          STAT_EMPTY: empty_removes++;
          default:    removed_ok++;
        endcase
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_INSERT;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    capacity_setting = 64;
    idle_on = 1'b1;
    errors = 0;
    requests_sent = 0;
    settings_used = 0;
    removed_ok = 0;
    full_drops = 0;
    empty_removes = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_value_extremes();
    test_capacity_corners();
    test_random_settings();
    test_full_rate_tail();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d requests over %0d capacity writes, limits 0 to 127", requests_sent,
             settings_used);
    $display("results: %0d inserts or removes ok, %0d dropped full, %0d removes on empty",
             removed_ok, full_drops, empty_removes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
